@@ rtl/flash_write_packer_with_erase_map_assert.svh @@
// Assertion macros for the flash write packer.
// Used by flash_write_packer_with_erase_map.sv; expects i_clk and i_rst_n in scope.
`ifndef FLASH_WRITE_PACKER_WITH_ERASE_MAP_ASSERT_SVH
`define FLASH_WRITE_PACKER_WITH_ERASE_MAP_ASSERT_SVH

// check cons in the same cycle as ante
`define FWPEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define FWPEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fwpem_pkg.sv @@
// Shared widths, command codes and parameter defaults for the flash write packer.
// No dependencies.
package fwpem_pkg;

    localparam int OFS_W  = 20;
    localparam int DATA_W = 8;
    localparam int WORD_W = 32;
    localparam int WIDX_W = OFS_W - 2;
    localparam int ROW_W  = 16;
    localparam int ROW_SH = 4;

    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 20;

    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic CMD_ERASE   = 1'b0;
    localparam logic CMD_PROGRAM = 1'b1;

endpackage

@@ rtl/flash_write_packer_with_erase_map.sv @@
// Flash write packer: one input byte per cycle when not stalled, up to three commands per byte.
// A byte is registered in the s1 stage, then each of its commands in the output register.
// Throughput: one byte per cycle while each byte causes at most one command and the output
// is not stalled; a byte causing several commands holds the input while they load, one per free cycle.
// The erase map is a 16-bit-row memory read on request and written when the byte retires.
// Reset: synchronous, clears row valid bits at once; no clearing pass.
module flash_write_packer_with_erase_map
    import fwpem_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [19:0] byte_offset, [27:20] data_byte, [31:28] zero
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [19:0] target_offset, [51:20] program_word, [55:52] zero
    output logic [55:0] o_m_tdata,
    // [0] command_kind
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int PAGE_SH = $clog2(PAGE_BYTES);
    localparam int ROWS    = (PAGE_COUNT + ROW_W - 1) / ROW_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [OFS_W-1:0] OFS_MASK = (OFFSET_BITS >= OFS_W) ? {OFS_W{1'b1}} :
        OFS_W'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [OFS_W-1:0] PAGE_MASK = OFS_W'(PAGE_BYTES - 1);

    logic [ROW_W-1:0]  r_map_mem [ROWS];
    logic [ROWS-1:0]   r_row_valid;

    logic [OFS_W-1:0]  in_off;
    logic [OFS_W-1:0]  in_page;
    logic [ROW_AW-1:0] in_row;
    logic              accept;

    logic              r_s1_valid;
    logic [WIDX_W-1:0] r_s1_widx;
    logic [1:0]        r_s1_lane;
    logic [DATA_W-1:0] r_s1_data;
    logic              r_s1_eob;
    logic              r_s1_in_map;
    logic [ROW_AW-1:0] r_s1_row;
    logic [ROW_SH-1:0] r_s1_bit;
    logic [OFS_W-1:0]  r_s1_page_base;
    logic              r_s1_fw;
    logic [ROW_W-1:0]  r_s1_fw_data;
    logic [ROW_W-1:0]  r_rd_data;
    logic [2:0]        r_sent;

    logic [WORD_W-1:0] r_word;
    logic [WIDX_W-1:0] r_widx;
    logic              r_open;

    logic              r_o_valid;
    logic              r_o_kind;
    logic [OFS_W-1:0]  r_o_target;
    logic [WORD_W-1:0] r_o_word;
    logic              r_o_last;

    logic [ROW_W-1:0]  row_bits;
    logic [WORD_W-1:0] merged;
    logic              same_word;
    logic [2:0]        need;
    logic [2:0]        pend;
    logic [2:0]        sel;
    logic              load;
    logic              retire;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_data;
    logic              n_kind;
    logic [OFS_W-1:0]  n_target;
    logic [WORD_W-1:0] n_word;

    assign in_off  = i_s_tdata[OFS_W-1:0] & OFS_MASK;
    assign in_page = in_off >> PAGE_SH;
    assign in_row  = in_page[ROW_AW+ROW_SH-1:ROW_SH];
    assign accept  = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_s1_fw) begin
            row_bits = r_s1_fw_data;
        end else if (r_row_valid[r_s1_row]) begin
            row_bits = r_rd_data;
        end else begin
            row_bits = '0;
        end
        same_word = r_open && (r_s1_widx == r_widx);
        merged = same_word ? r_word : ALL_ONES;
        merged[r_s1_lane*8 +: 8] = r_s1_data;
        need[0] = r_open && !same_word && (r_word != ALL_ONES);
        need[1] = r_s1_in_map && !row_bits[r_s1_bit];
        need[2] = r_s1_eob && (merged != ALL_ONES);
        pend = need & ~r_sent;
        sel  = pend & (~pend + 3'd1);
        case (1'b1)
            sel[0]: begin
                n_kind   = CMD_PROGRAM;
                n_target = {r_widx, 2'b00};
                n_word   = r_word;
            end
            sel[1]: begin
                n_kind   = CMD_ERASE;
                n_target = r_s1_page_base;
                n_word   = '0;
            end
            default: begin
                n_kind   = CMD_PROGRAM;
                n_target = {r_s1_widx, 2'b00};
                n_word   = merged;
            end
        endcase
    end

    assign load    = r_s1_valid && (pend != 3'b000) && (!r_o_valid || i_m_tready);
    assign retire  = r_s1_valid && ((pend == 3'b000) || (load && ((pend & ~sel) == 3'b000)));
    assign wr_en   = retire && need[1];
    assign wr_data = row_bits | (ROW_W'(1) << r_s1_bit);
    assign o_s_tready = !r_s1_valid || retire;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map_mem[r_s1_row] <= wr_data;
        end
        if (accept) begin
            r_rd_data <= r_map_mem[in_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_s1_valid  <= 1'b0;
            r_sent      <= '0;
            r_open      <= 1'b0;
            r_word      <= ALL_ONES;
            r_widx      <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[r_s1_row] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (retire) begin
                r_s1_valid <= 1'b0;
            end
            if (retire) begin
                r_sent <= '0;
                r_widx <= r_s1_widx;
                r_open <= !r_s1_eob;
                r_word <= r_s1_eob ? ALL_ONES : merged;
            end else if (load) begin
                r_sent <= r_sent | sel;
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_widx      <= in_off[OFS_W-1:2];
            r_s1_lane      <= in_off[1:0];
            r_s1_data      <= i_s_tdata[OFS_W+DATA_W-1:OFS_W];
            r_s1_eob       <= i_s_tlast;
            r_s1_in_map    <= in_page < OFS_W'(PAGE_COUNT);
            r_s1_row       <= in_row;
            r_s1_bit       <= in_page[ROW_SH-1:0];
            r_s1_page_base <= in_off & ~PAGE_MASK;
            r_s1_fw        <= wr_en && (r_s1_row == in_row);
            r_s1_fw_data   <= wr_data;
        end
        if (load) begin
            r_o_kind   <= n_kind;
            r_o_target <= n_target;
            r_o_word   <= n_word;
            r_o_last   <= (pend & ~sel) == 3'b000;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {4'd0, r_o_word, r_o_target};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

`include "flash_write_packer_with_erase_map_assert.svh"

    `FWPEM_ASSERT_NOW(a_no_overrun, accept, !r_s1_valid || retire, "request overran held byte")
    `FWPEM_ASSERT_NOW(a_map_bound, wr_en, r_s1_in_map, "map write outside page range")
    `FWPEM_ASSERT_NOW(a_erase_once, wr_en, !row_bits[r_s1_bit], "page erased twice")
    `FWPEM_ASSERT_NEXT(a_hold_item, r_s1_valid && !retire, r_s1_valid, "held byte dropped")

endmodule

@@ tb/tb_flash_write_packer_with_erase_map.sv @@
// Self-checking testbench for flash_write_packer_with_erase_map: byte requests in,
// erase and program commands out, compared against a behavioral command predictor.
// Depends on fwpem_pkg and the packer RTL only.
module tb_flash_write_packer_with_erase_map;
    import fwpem_pkg::*;

    typedef struct {
        logic [OFS_W-1:0]  ofs;
        logic [DATA_W-1:0] dat;
        logic              eob;
        int                gap;
    } byte_req_t;

    typedef struct packed {
        logic              cmd_kind;
        logic [OFS_W-1:0]  target;
        logic [WORD_W-1:0] word;
        logic              final_cmd;
    } flash_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_data;
    logic        m_user;
    logic        m_last;

    byte_req_t  byte_queue[$];
    flash_cmd_t flash_cmds[$];
    int         error_count = 0;

    bit                page_erased[PAGE_COUNT_DEF];
    logic [WORD_W-1:0] open_word = ALL_ONES;
    logic [WIDX_W-1:0] open_widx = '0;
    bit                word_live = 1'b0;

    logic byte_taken = 1'b0;
    int   gap_left = 0;
    bit   gap_spent = 1'b0;
    int   stall_left = 0;
    int   mode_left = 0;
    int   stall_mode = 0;

    flash_write_packer_with_erase_map dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    function automatic bit close_open_word(output flash_cmd_t cmd);
        bit emits;
        emits = word_live && (open_word != ALL_ONES);
        cmd = '{CMD_PROGRAM, {open_widx, 2'b00}, open_word, 1'b0};
        word_live = 1'b0;
        open_word = ALL_ONES;
        return emits;
    endfunction

    task automatic predict_commands(input logic [OFS_W-1:0] ofs, input logic [DATA_W-1:0] dat,
                                    input logic eob);
        flash_cmd_t  step_cmds[3];
        flash_cmd_t  cmd;
        int          n;
        int unsigned page;
        logic [WIDX_W-1:0] widx;
        n = 0;
        widx = ofs[OFS_W-1:2];
        page = ofs / PAGE_BYTES_DEF;
        if (word_live && widx != open_widx && close_open_word(cmd)) begin
            step_cmds[n] = cmd;
            n++;
        end
        if (page < PAGE_COUNT_DEF && !page_erased[page]) begin
            page_erased[page] = 1'b1;
            step_cmds[n] = '{CMD_ERASE, OFS_W'(page * PAGE_BYTES_DEF), '0, 1'b0};
            n++;
        end
        if (!word_live) begin
            word_live = 1'b1;
            open_word = ALL_ONES;
            open_widx = widx;
        end
        open_word[ofs[1:0]*8 +: 8] = dat;
        if (eob && close_open_word(cmd)) begin
            step_cmds[n] = cmd;
            n++;
        end
        if (n > 0)
            step_cmds[n-1].final_cmd = 1'b1;
        for (int k = 0; k < n; k++)
            flash_cmds.push_back(step_cmds[k]);
    endtask

    task automatic check_command();
        flash_cmd_t want;
        if (flash_cmds.size() == 0) begin
            report_mismatch("command with none pending", 64'(m_data), '0);
        end else begin
            want = flash_cmds.pop_front();
            if (m_user !== want.cmd_kind)
                report_mismatch("command_kind", 64'(m_user), 64'(want.cmd_kind));
            if (m_data[19:0] !== want.target)
                report_mismatch("target_offset", 64'(m_data[19:0]), 64'(want.target));
            if (m_data[51:20] !== want.word)
                report_mismatch("program_word", 64'(m_data[51:20]), 64'(want.word));
            if (m_last !== want.final_cmd)
                report_mismatch("final_of_run", 64'(m_last), 64'(want.final_cmd));
        end
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [OFS_W-1:0] ofs, input logic [DATA_W-1:0] dat,
                             input logic eob, input int gap);
        byte_req_t req;
        req.ofs = ofs;
        req.dat = dat;
        req.eob = eob;
        req.gap = gap;
        byte_queue.push_back(req);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (byte_queue.size() != 0 || s_valid || flash_cmds.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk) begin : watch
        byte_taken <= rst_n && s_valid && s_ready;
        if (rst_n) begin
            if (s_valid && s_ready)
                predict_commands(s_data[19:0], s_data[27:20], s_last);
            if (m_valid && m_ready)
                check_command();
        end
    end

    always @(negedge clk) begin : drive_bytes
        byte_req_t front;
        if (rst_n && (!s_valid || byte_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (byte_queue.size() > 0 && !gap_spent && byte_queue[0].gap > 0) begin
                gap_left <= byte_queue[0].gap - 1;
                gap_spent <= 1'b1;
                s_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                front = byte_queue.pop_front();
                s_data <= {4'b0000, front.dat, front.ofs};
                s_last <= front.eob;
                s_valid <= 1'b1;
                gap_spent <= 1'b0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin : drive_ready
        if (mode_left == 0) begin
            mode_left <= $urandom_range(20, 200);
            stall_mode <= $urandom_range(0, 2);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (stall_mode != 0 &&
                     $urandom_range(0, 99) < (stall_mode == 1 ? 20 : 40)) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [7:0]       page_pool[4];
        logic [OFS_W-1:0] base;
        logic [DATA_W-1:0] dat;
        int  sent;
        int  len;
        int  pick;
        bit  quiet;
        bit  paused;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_byte(20'h00000, 8'h00, 1'b0, 0);
        push_byte(20'h00001, 8'hFF, 1'b0, 0);
        push_byte(20'h00001, 8'hA5, 1'b0, 0);
        push_byte(20'h00003, 8'h5A, 1'b1, 0);
        push_byte(20'h00004, 8'hFF, 1'b1, 0);
        push_byte(20'hFFFFF, 8'hFF, 1'b0, 0);
        push_byte(20'hFFFFC, 8'h00, 1'b0, 2);
        push_byte(20'h12344, 8'h11, 1'b0, 0);
        push_byte(20'h23450, 8'h22, 1'b1, 0);
        push_byte(20'h23454, 8'hFF, 1'b0, 0);
        push_byte(20'h23455, 8'hFF, 1'b0, 0);
        push_byte(20'h23458, 8'h33, 1'b0, 0);
        push_byte(20'h2345B, 8'h80, 1'b1, 0);
        push_byte(20'h7FFFF, 8'h7F, 1'b0, 0);
        push_byte(20'h80000, 8'h01, 1'b1, 0);
        push_byte(20'h80004, 8'hFF, 1'b0, 0);
        push_byte(20'h80005, 8'hFF, 1'b0, 0);
        push_byte(20'h80006, 8'hFF, 1'b0, 0);
        push_byte(20'h80007, 8'hFF, 1'b1, 0);
        push_byte(20'hAAAAA, 8'h55, 1'b0, 0);
        push_byte(20'h55555, 8'hAA, 1'b0, 0);
        push_byte(20'h55556, 8'hC3, 1'b1, 0);
        wait_drained();
        repeat (8) @(posedge clk);

        foreach (page_pool[i])
            page_pool[i] = 8'($urandom);
        sent = 0;
        paused = 1'b0;
        while (sent < 100) begin
            if (sent >= 50 && !paused) begin
                wait_drained();
                repeat (8) @(posedge clk);
                paused = 1'b1;
            end
            quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                base = (pick < 35) ? {page_pool[$urandom_range(0, 3)], 12'($urandom)}
                                   : 20'($urandom);
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    dat = ($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom);
                    push_byte(base + 20'(k), dat,
                              (k == len - 1) && ($urandom_range(0, 4) != 0),
                              pick_gap(quiet));
                end
                sent += len;
            end else if (pick < 85) begin
                base = {18'($urandom), 2'b00};
                for (int k = 0; k < 4; k++)
                    push_byte(base + 20'(k), 8'hFF, k == 3, pick_gap(quiet));
                sent += 4;
            end else begin
                push_byte(20'($urandom), 8'($urandom), 1'($urandom), pick_gap(quiet));
                sent++;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
